// ===== hdl/framed_message_validator_macros.svh =====
// Assertion macros for the framed message validator.
// Depends on a clock named clk and a synchronous active-low reset named rst_n.
`ifndef FRAMED_MESSAGE_VALIDATOR_MACROS_SVH
`define FRAMED_MESSAGE_VALIDATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FMV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FMV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fmv_pkg.sv =====
// Shared types and constants of the framed message validator.
// No dependencies; used by every module of the block.
package fmv_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [KIND_W-1:0] KIND_DATA = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OK   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ADDR = 3'd2;
  localparam logic [KIND_W-1:0] KIND_END  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SUM  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ADDR  = 2'd2;

  localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'h02;
  localparam logic [BYTE_W-1:0] END_BYTE_RST    = 8'h03;
  localparam logic [BYTE_W-1:0] OWN_ADDRESS_RST = 8'h04;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] end_byte;
    logic [BYTE_W-1:0] own_address;
  } fmv_cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  data_byte;
    logic [COUNT_W-1:0] good_count;
    logic [COUNT_W-1:0] error_count;
  } fmv_res_t;

endpackage

// ===== hdl/fmv_cfg_regs.sv =====
// Configuration registers of the framed message validator.
// Depends on fmv_pkg.
module fmv_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [fmv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fmv_pkg::BYTE_W-1:0]      cfg_wdata,
  output fmv_pkg::fmv_cfg_t               cfg
);

  fmv_pkg::fmv_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte  <= fmv_pkg::START_BYTE_RST;
      cfg_r.end_byte    <= fmv_pkg::END_BYTE_RST;
      cfg_r.own_address <= fmv_pkg::OWN_ADDRESS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        fmv_pkg::CFG_IDX_START: cfg_r.start_byte  <= cfg_wdata;
        fmv_pkg::CFG_IDX_END:   cfg_r.end_byte    <= cfg_wdata;
        fmv_pkg::CFG_IDX_ADDR:  cfg_r.own_address <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/fmv_parser.sv =====
// Frame parser state machine: phase, checksum accumulation and frame counters.
// Depends on fmv_pkg.
module fmv_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [fmv_pkg::BYTE_W-1:0]  rx_byte,
  input  fmv_pkg::fmv_cfg_t           cfg,
  output logic                        res_valid,
  output fmv_pkg::fmv_res_t           res
);

  typedef enum logic [2:0] {
    PH_HUNT, PH_ADDR, PH_LEN, PH_DATA, PH_CHECK, PH_STAMP, PH_END
  } phase_t;

  phase_t                       phase_r, phase_nxt;
  logic [fmv_pkg::BYTE_W-1:0]   remaining_r, remaining_nxt;
  logic [fmv_pkg::BYTE_W-1:0]   sum_r, sum_nxt;
  logic [fmv_pkg::BYTE_W-1:0]   check_r, check_nxt;
  logic [fmv_pkg::COUNT_W-1:0]  good_r, good_nxt;
  logic [fmv_pkg::COUNT_W-1:0]  err_r, err_nxt;
  logic                         emit;
  logic [fmv_pkg::KIND_W-1:0]   kind;
  logic [fmv_pkg::BYTE_W-1:0]   data;

  always_comb begin
    phase_nxt     = phase_r;
    remaining_nxt = remaining_r;
    sum_nxt       = sum_r;
    check_nxt     = check_r;
    good_nxt      = good_r;
    err_nxt       = err_r;
    emit          = 1'b0;
    kind          = fmv_pkg::KIND_DATA;
    data          = '0;
    case (phase_r)
      PH_HUNT: begin
        if (rx_byte == cfg.start_byte) phase_nxt = PH_ADDR;
      end
      PH_ADDR: begin
        if (rx_byte == cfg.own_address) begin
          phase_nxt = PH_LEN;
        end else begin
          phase_nxt = PH_HUNT;
          err_nxt   = err_r + 1'b1;
          emit      = 1'b1;
          kind      = fmv_pkg::KIND_ADDR;
        end
      end
      PH_LEN: begin
        remaining_nxt = rx_byte;
        sum_nxt       = rx_byte;
        phase_nxt     = (rx_byte == '0) ? PH_CHECK : PH_DATA;
      end
      PH_DATA: begin
        sum_nxt       = sum_r + rx_byte;
        remaining_nxt = remaining_r - 1'b1;
        if (remaining_r == 8'd1) phase_nxt = PH_CHECK;
        emit = 1'b1;
        kind = fmv_pkg::KIND_DATA;
        data = rx_byte;
      end
      PH_CHECK: begin
        check_nxt = rx_byte;
        phase_nxt = PH_STAMP;
      end
      PH_STAMP: begin
        sum_nxt   = sum_r + rx_byte;
        phase_nxt = PH_END;
      end
      PH_END: begin
        phase_nxt = PH_HUNT;
        emit      = 1'b1;
        if (rx_byte != cfg.end_byte) begin
          err_nxt = err_r + 1'b1;
          kind    = fmv_pkg::KIND_END;
        end else if (sum_r != check_r) begin
          err_nxt = err_r + 1'b1;
          kind    = fmv_pkg::KIND_SUM;
        end else begin
          good_nxt = good_r + 1'b1;
          kind     = fmv_pkg::KIND_OK;
        end
      end
      default: phase_nxt = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      remaining_r <= '0;
      sum_r       <= '0;
      check_r     <= '0;
      good_r      <= '0;
      err_r       <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      remaining_r <= remaining_nxt;
      sum_r       <= sum_nxt;
      check_r     <= check_nxt;
      good_r      <= good_nxt;
      err_r       <= err_nxt;
    end
  end

  assign res_valid       = step & emit;
  assign res.kind        = kind;
  assign res.data_byte   = data;
  assign res.good_count  = good_nxt;
  assign res.error_count = err_nxt;

endmodule

// ===== hdl/fmv_out_reg.sv =====
// Result register of the framed message validator with valid/ready output.
// Depends on fmv_pkg.
module fmv_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  fmv_pkg::fmv_res_t  res,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output fmv_pkg::fmv_res_t  out_res
);

  logic              valid_r;
  fmv_pkg::fmv_res_t res_r;

  assign room = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (room) begin
      valid_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (room && push) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== hdl/framed_message_validator.sv =====
// Channel  | Handshake            | Payload
// input    | in_valid / in_ready  | in_rx_byte
// result   | out_valid/ out_ready | out_kind, out_data_byte, out_good_count, out_error_count
// config   | cfg_wr_en            | cfg_index, cfg_wdata
//
// One received byte is taken per cycle unless a stalled result holds the input. Each byte
// sits in the input register; its result, if any, goes to the result register when consumed.
// The synchronous reset returns the parser to hunting, clears both counters and restores
// the configuration defaults. A stalled result holds the input register, which then
// holds in_ready low until the result transfer completes.
// Depends on fmv_pkg, fmv_cfg_regs, fmv_parser, fmv_out_reg and the macros header.
`include "framed_message_validator_macros.svh"

module framed_message_validator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [fmv_pkg::BYTE_W-1:0]     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fmv_pkg::KIND_W-1:0]     out_kind,
  output logic [fmv_pkg::BYTE_W-1:0]     out_data_byte,
  output logic [fmv_pkg::COUNT_W-1:0]    out_good_count,
  output logic [fmv_pkg::COUNT_W-1:0]    out_error_count,
  input  logic                           cfg_wr_en,
  input  logic [fmv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fmv_pkg::BYTE_W-1:0]     cfg_wdata
);

  fmv_pkg::fmv_cfg_t          cfg;
  fmv_pkg::fmv_res_t          res;
  fmv_pkg::fmv_res_t          out_res;
  logic                       s1_valid_r;
  logic [fmv_pkg::BYTE_W-1:0] s1_byte_r;
  logic                       room;
  logic                       consume;
  logic                       res_valid;

  assign consume  = s1_valid_r && room;
  assign in_ready = !s1_valid_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  fmv_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fmv_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (consume),
    .rx_byte   (s1_byte_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  fmv_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind        = out_res.kind;
  assign out_data_byte   = out_res.data_byte;
  assign out_good_count  = out_res.good_count;
  assign out_error_count = out_res.error_count;

  `FMV_ASSERT_NOW(a_data_zero, out_valid && (out_kind != fmv_pkg::KIND_DATA), out_data_byte == '0, "data byte set on a frame report")
  `FMV_ASSERT_NOW(a_ready_only_full, !in_ready, s1_valid_r && out_valid && !out_ready, "input stalled without a stalled result")
  `FMV_ASSERT_NEXT(a_s1_held, s1_valid_r && !consume, s1_valid_r && $stable(s1_byte_r), "held input byte lost")

endmodule

// ===== tb/sv/framed_message_validator_checker.sv =====
`timescale 1ns / 1ps
// Checker for the framed message validator: watches the byte, result and register ports,
// predicts each result and compares it with what arrives. Depends on fmv_pkg only.
module framed_message_validator_checker import fmv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [KIND_W-1:0]    out_kind,
  input  logic [BYTE_W-1:0]    out_data_byte,
  input  logic [COUNT_W-1:0]   out_good_count,
  input  logic [COUNT_W-1:0]   out_error_count,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  output int                   mismatches,
  output int                   pending
);

  typedef enum logic [2:0] {
    P_HUNT, P_ADDR, P_LEN, P_DATA, P_CHECK, P_STAMP, P_TAIL
  } frame_phase_e;

  fmv_cfg_t           regs;
  frame_phase_e       phase;
  logic [BYTE_W-1:0]  remaining;
  logic [BYTE_W-1:0]  run_sum;
  logic [BYTE_W-1:0]  rx_check;
  logic [COUNT_W-1:0] good_total;
  logic [COUNT_W-1:0] bad_total;
  fmv_res_t           expected_results[$];

  initial begin
    mismatches = 0;
    pending = 0;
  end

  task report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task push_result(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] data);
    fmv_res_t r;
    r.kind = kind;
    r.data_byte = data;
    r.good_count = good_total;
    r.error_count = bad_total;
    expected_results.push_back(r);
  endtask

  task parse_byte(input logic [BYTE_W-1:0] b);
    case (phase)
      P_HUNT: begin
        if (b == regs.start_byte) phase = P_ADDR;
      end
      P_ADDR: begin
        if (b == regs.own_address) begin
          phase = P_LEN;
        end else begin
          phase = P_HUNT;
          bad_total = bad_total + 1'b1;
          push_result(KIND_ADDR, '0);
        end
      end
      P_LEN: begin
        remaining = b;
        run_sum = b;
        phase = (b == '0) ? P_CHECK : P_DATA;
      end
      P_DATA: begin
        run_sum = run_sum + b;
        remaining = remaining - 1'b1;
        if (remaining == '0) phase = P_CHECK;
        push_result(KIND_DATA, b);
      end
      P_CHECK: begin
        rx_check = b;
        phase = P_STAMP;
      end
      P_STAMP: begin
        run_sum = run_sum + b;
        phase = P_TAIL;
      end
      P_TAIL: begin
        phase = P_HUNT;
        if (b != regs.end_byte) begin
          bad_total = bad_total + 1'b1;
          push_result(KIND_END, '0);
        end else if (run_sum != rx_check) begin
          bad_total = bad_total + 1'b1;
          push_result(KIND_SUM, '0);
        end else begin
          good_total = good_total + 1'b1;
          push_result(KIND_OK, '0);
        end
      end
      default: phase = P_HUNT;
    endcase
  endtask

  task check_result();
    fmv_res_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result transfer with nothing expected, kind %0d", out_kind));
    end else begin
      want = expected_results.pop_front();
      if (out_kind !== want.kind)
        report_mismatch($sformatf("kind %0d, expected %0d", out_kind, want.kind));
      if (out_data_byte !== want.data_byte)
        report_mismatch($sformatf("data_byte %0h, expected %0h", out_data_byte,
                                  want.data_byte));
      if (out_good_count !== want.good_count)
        report_mismatch($sformatf("good_count %0d, expected %0d", out_good_count,
                                  want.good_count));
      if (out_error_count !== want.error_count)
        report_mismatch($sformatf("error_count %0d, expected %0d", out_error_count,
                                  want.error_count));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs.start_byte = START_BYTE_RST;
      regs.end_byte = END_BYTE_RST;
      regs.own_address = OWN_ADDRESS_RST;
      phase = P_HUNT;
      remaining = '0;
      run_sum = '0;
      rx_check = '0;
      good_total = '0;
      bad_total = '0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) parse_byte(in_rx_byte);
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_IDX_START: regs.start_byte = cfg_wdata;
          CFG_IDX_END:   regs.end_byte = cfg_wdata;
          CFG_IDX_ADDR:  regs.own_address = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== tb/sv/framed_message_validator_tb.sv =====
`timescale 1ns / 1ps
// Top of the framed message validator testbench: clock, reset, framed byte stimulus,
// register settings and the verdict. Depends on fmv_pkg, the block and its checker.
module framed_message_validator_tb;
  import fmv_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam int unsigned TAIL_CYCLES = 4;

  typedef enum int {FL_NONE, FL_ADDR, FL_END, FL_SUM, FL_CUT} frame_flaw_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [BYTE_W-1:0]    in_rx_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic [KIND_W-1:0]    out_kind;
  logic [BYTE_W-1:0]    out_data_byte;
  logic [COUNT_W-1:0]   out_good_count;
  logic [COUNT_W-1:0]   out_error_count;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_wdata;
  int                   mismatches;
  int                   pending;

  logic [BYTE_W-1:0]    start_val;
  logic [BYTE_W-1:0]    end_val;
  logic [BYTE_W-1:0]    addr_val;
  bit                   steady;
  int                   frame_byte_count;

  framed_message_validator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_data_byte(out_data_byte), .out_good_count(out_good_count),
    .out_error_count(out_error_count),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  framed_message_validator_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_data_byte(out_data_byte), .out_good_count(out_good_count),
    .out_error_count(out_error_count),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int draw_gap();
    return steady ? 0 : int'($urandom_range(0, 12));
  endfunction

  // Called at a rising edge; returns at the edge where the transfer happens.
  task send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task send_frame(input logic [BYTE_W-1:0] payload[$], input frame_flaw_t flaw);
    logic [BYTE_W-1:0] bytes[$];
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] stamp;
    int cut;
    stamp = $urandom_range(0, 255);
    sum = BYTE_W'(payload.size()) + stamp;
    foreach (payload[i]) sum = sum + payload[i];
    bytes.push_back(start_val);
    if (flaw == FL_ADDR) begin
      bytes.push_back(addr_val ^ BYTE_W'($urandom_range(1, 255)));
    end else begin
      bytes.push_back(addr_val);
      bytes.push_back(BYTE_W'(payload.size()));
      foreach (payload[i]) bytes.push_back(payload[i]);
      bytes.push_back(flaw == FL_SUM ? sum ^ BYTE_W'($urandom_range(1, 255)) : sum);
      bytes.push_back(stamp);
      bytes.push_back(flaw == FL_END ? end_val ^ BYTE_W'($urandom_range(1, 255)) : end_val);
    end
    cut = (flaw == FL_CUT) ? int'($urandom_range(1, bytes.size() - 1)) : bytes.size();
    for (int i = 0; i < cut; i++) send_byte(bytes[i]);
    frame_byte_count += cut;
  endtask

  task send_random_frame(input int len);
    logic [BYTE_W-1:0] payload[$];
    int pick;
    frame_flaw_t flaw;
    steady = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom_range(0, 255)));
    end
    repeat (len) payload.push_back(BYTE_W'($urandom_range(0, 255)));
    pick = $urandom_range(0, 19);
    case (pick)
      0, 1:    flaw = FL_ADDR;
      2, 3:    flaw = FL_END;
      4, 5:    flaw = FL_SUM;
      6:       flaw = FL_CUT;
      default: flaw = FL_NONE;
    endcase
    send_frame(payload, flaw);
  endtask

  task run_random_frames(input int target, input bit with_longest);
    frame_byte_count = 0;
    if (with_longest) send_random_frame(255);
    while (frame_byte_count < target) begin
      send_random_frame(($urandom_range(0, 5) == 0) ? 0 : int'($urandom_range(1, 6)));
    end
    steady = 1'b0;
  endtask

  // Returns at a rising edge once every expected result has arrived and the pipeline drained.
  task wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task program_regs(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e,
                    input logic [BYTE_W-1:0] a);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_IDX_START;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_index <= CFG_IDX_END;
    cfg_wdata <= e;
    @(posedge clk);
    cfg_index <= CFG_IDX_ADDR;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_index <= CFG_IDX_SPARE;
    cfg_wdata <= BYTE_W'($urandom_range(0, 255));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    start_val = s;
    end_val = e;
    addr_val = a;
  endtask

  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    logic [BYTE_W-1:0] payload[$];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_IDX_START;
    cfg_wdata = '0;
    steady = 1'b0;
    start_val = START_BYTE_RST;
    end_val = END_BYTE_RST;
    addr_val = OWN_ADDRESS_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: noise while hunting, empty frame, start byte inside the payload,
    // and one frame for each kind of rejection.
    send_byte(8'h00);
    send_byte(8'hFF);
    payload = {};
    send_frame(payload, FL_NONE);
    payload = {8'h00, 8'hFF, start_val};
    send_frame(payload, FL_NONE);
    payload = {};
    send_frame(payload, FL_ADDR);
    payload = {8'h5A};
    send_frame(payload, FL_END);
    payload = {};
    send_frame(payload, FL_SUM);
    wait_idle();

    program_regs(8'h00, 8'hFF, 8'hFF);
    run_random_frames(55, 1'b0);
    wait_idle();

    program_regs(8'hFF, 8'h00, 8'h00);
    run_random_frames(55, 1'b0);
    wait_idle();

    program_regs(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                 BYTE_W'($urandom_range(0, 255)));
    run_random_frames(60, 1'b1);
    wait_idle();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
